### rtl/core/efta_pkg.sv
`default_nettype none

package efta_pkg;

  // Defaults for the top-level parameters.
  localparam int ENCODER_COUNT_DEF = 4;
  localparam int FRAME_BYTES_DEF   = 30;

  // Fixed layout of the telemetry frame and the encoder table.
  localparam int SLOT_COUNT  = 4;
  localparam int SLOT_BITS   = 2;
  localparam int QUEUE_DEPTH = 2;

  // Configuration reset value.
  localparam logic [4:0] RES_RESET = 5'd18;

  // Header bytes that follow the encoder id in a position message.
  localparam logic [7:0] MSG_B1 = 8'h03;
  localparam logic [7:0] MSG_B2 = 8'h04;
  localparam logic [7:0] MSG_B3 = 8'h00;

  // Hundredths of a degree per revolution, and the largest storable angle.
  localparam logic [15:0] DEG_SCALE = 16'd36000;
  localparam logic [21:0] ANGLE_MAX = 22'h3fffff;

  // Reciprocals of 100 for exact division of 22-bit and 16-bit values.
  localparam logic [22:0] RECIP_A = 23'd5368710;
  localparam int          SHIFT_A = 29;
  localparam logic [16:0] RECIP_B = 17'd83887;
  localparam int          SHIFT_B = 23;

  // Fixed frame bytes.
  localparam logic [7:0] HEAD0 = 8'hff;
  localparam logic [7:0] HEAD1 = 8'h00;
  localparam logic [7:0] HEAD2 = 8'hee;
  localparam logic [7:0] TAIL0 = 8'hab;
  localparam logic [7:0] TAIL1 = 8'hff;
  localparam logic [7:0] TAIL2 = 8'hcd;

  typedef struct packed {
    logic       func;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       frame_last;
  } result_t;

  // Angle split into the three frame bytes of one encoder.
  typedef struct packed {
    logic [7:0] hi;
    logic [7:0] mid;
    logic [7:0] lo;
  } digits_t;

  typedef digits_t [SLOT_COUNT-1:0] snap_t;

  // One frame snapshot moving through the queue.
  typedef struct packed {
    logic  valid;
    snap_t snap;
  } link_t;

  // Status of the frame emitter.
  typedef struct packed {
    logic active;
    logic take;
  } back_stat_t;

  function automatic logic [7:0] slot_marker(input logic [SLOT_BITS-1:0] k);
    logic [7:0] m;
    unique case (k)
      2'd0: m = 8'haa;
      2'd1: m = 8'hbb;
      2'd2: m = 8'hcc;
      2'd3: m = 8'hdd;
      default: m = 8'h00;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

### rtl/core/efta_front.sv
`default_nettype none

module efta_front #(
  parameter int ENCODER_COUNT = efta_pkg::ENCODER_COUNT_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cfg_we,
  input  wire logic [4:0]     cfg_data,
  input  wire logic           push,
  input  wire efta_pkg::item_t item,
  output logic                full,
  input  wire logic           q_full,
  output efta_pkg::link_t     snap_out
);

  logic [7:0] win [6];
  logic [4:0] res;

  logic       stall;
  logic       accept;
  logic       match;
  logic       enter;
  logic [23:0] count;

  // Pipeline stage registers.
  logic        a_valid, a_send;
  logic [1:0]  a_id;
  logic [39:0] a_prod;
  logic        b_valid, b_send;
  logic [1:0]  b_id;
  logic [21:0] b_ang;
  logic        c_valid, c_send;
  logic [1:0]  c_id;
  logic [21:0] c_ang;
  logic [15:0] c_q;
  logic        d_valid, d_send;
  logic [1:0]  d_id;
  logic [15:0] d_q;
  logic [8:0]  d_q2;
  logic [7:0]  d_lo;

  logic [39:0] shifted;
  logic [21:0] angle;
  logic [44:0] prod_a;
  logic [32:0] prod_b;
  logic [21:0] lo_full;
  logic [15:0] mid_full;

  efta_pkg::digits_t store [efta_pkg::SLOT_COUNT];

  // The whole pipeline holds only while a send waits for queue space.
  assign stall  = d_valid && d_send && q_full;
  assign full   = stall;
  assign accept = push && !stall;

  // Position message: id, three header bytes, then the 24-bit count.
  assign match = (win[0] >= 8'd1) && (win[0] <= 8'(ENCODER_COUNT)) &&
                 (win[1] == efta_pkg::MSG_B1) && (win[2] == efta_pkg::MSG_B2) &&
                 (win[3] == efta_pkg::MSG_B3);
  assign count = {win[4], win[5], item.rx_byte};
  assign enter = accept && (item.func || match);

  // Scale the count and saturate to the 22-bit angle.
  assign shifted = a_prod >> res;
  assign angle   = (|shifted[39:22]) ? efta_pkg::ANGLE_MAX : shifted[21:0];

  // Split the angle into base-100 digits by reciprocal multiplication.
  assign prod_a   = 45'(b_ang) * 45'(efta_pkg::RECIP_A);
  assign prod_b   = 33'(c_q) * 33'(efta_pkg::RECIP_B);
  assign lo_full  = c_ang - 22'(c_q) * 22'd100;
  assign mid_full = d_q - 16'(d_q2) * 16'd100;

  // Configuration register and receive window.
  always_ff @(posedge clk) begin
    if (rst) begin
      res <= efta_pkg::RES_RESET;
      for (int i = 0; i < 6; i++) begin
        win[i] <= 8'h00;
      end
    end else begin
      if (cfg_we) begin
        res <= cfg_data;
      end
      if (accept && !item.func) begin
        for (int i = 0; i < 5; i++) begin
          win[i] <= win[i+1];
        end
        win[5] <= item.rx_byte;
      end
    end
  end

  // Pipeline valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      d_valid <= 1'b0;
    end else if (!stall) begin
      a_valid <= enter;
      b_valid <= a_valid;
      c_valid <= b_valid;
      d_valid <= c_valid;
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk) begin
    if (!stall) begin
      a_send <= item.func;
      a_id   <= 2'(win[0] - 8'd1);
      a_prod <= 40'(count) * 40'(efta_pkg::DEG_SCALE);
      b_send <= a_send;
      b_id   <= a_id;
      b_ang  <= angle;
      c_send <= b_send;
      c_id   <= b_id;
      c_ang  <= b_ang;
      c_q    <= prod_a[efta_pkg::SHIFT_A +: 16];
      d_send <= c_send;
      d_id   <= c_id;
      d_q    <= c_q;
      d_q2   <= prod_b[efta_pkg::SHIFT_B +: 9];
      d_lo   <= lo_full[7:0];
    end
  end

  // Digit store per encoder; a finished angle lands here.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < efta_pkg::SLOT_COUNT; i++) begin
        store[i] <= '0;
      end
    end else if (d_valid && !d_send) begin
      store[d_id] <= '{hi: d_q2[7:0], mid: mid_full[7:0], lo: d_lo};
    end
  end

  // A send at the end of the pipeline copies the store into the queue.
  always_comb begin
    snap_out.valid = d_valid && d_send && !q_full;
    for (int i = 0; i < efta_pkg::SLOT_COUNT; i++) begin
      snap_out.snap[i] = store[i];
    end
  end

endmodule

`default_nettype wire

### rtl/core/efta_queue.sv
`default_nettype none

module efta_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire efta_pkg::link_t in_link,
  output logic                 full,
  output efta_pkg::link_t      head,
  input  wire logic            take
);

  localparam int PW = $clog2(efta_pkg::QUEUE_DEPTH);
  localparam int CW = $clog2(efta_pkg::QUEUE_DEPTH + 1);

  efta_pkg::snap_t ent [efta_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] fill;
  logic          do_push;
  logic          do_pop;

  assign full       = (fill == CW'(efta_pkg::QUEUE_DEPTH));
  assign do_push    = in_link.valid && !full;
  assign do_pop     = take && (fill != '0);
  assign head.valid = (fill != '0);
  assign head.snap  = ent[rd_ptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(efta_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(efta_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      ent[wr_ptr] <= in_link.snap;
    end
  end

endmodule

`default_nettype wire

### rtl/core/efta_back.sv
`default_nettype none

module efta_back #(
  parameter int FRAME_BYTES = efta_pkg::FRAME_BYTES_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire efta_pkg::link_t head,
  output efta_pkg::back_stat_t stat,
  output logic                 empty,
  input  wire logic            pop,
  output efta_pkg::result_t    result
);

  localparam int IW = $clog2(FRAME_BYTES);

  logic              active;
  logic [IW-1:0]     idx;
  efta_pkg::snap_t   snap;
  logic              out_valid;
  logic              slot_free;
  logic              take;
  logic              emit;
  logic              last;
  logic [IW-1:0]     rel;
  logic [7:0]        fbyte;
  efta_pkg::digits_t dg;

  assign slot_free = !out_valid || pop;
  assign take      = !active && head.valid;
  assign emit      = active && slot_free;
  assign last      = (idx == IW'(FRAME_BYTES - 1));
  assign empty     = !out_valid;
  assign stat      = '{active: active, take: take};

  // Frame byte at the current index.
  assign rel = idx - IW'(3);
  assign dg  = snap[rel[3:2]];
  always_comb begin
    fbyte = 8'h00;
    if (idx == IW'(0)) begin
      fbyte = efta_pkg::HEAD0;
    end else if (idx == IW'(1)) begin
      fbyte = efta_pkg::HEAD1;
    end else if (idx == IW'(2)) begin
      fbyte = efta_pkg::HEAD2;
    end else if (idx <= IW'(18)) begin
      unique case (rel[1:0])
        2'd0:    fbyte = efta_pkg::slot_marker(rel[3:2]);
        2'd1:    fbyte = dg.hi;
        2'd2:    fbyte = dg.mid;
        default: fbyte = dg.lo;
      endcase
    end else if (idx == IW'(19)) begin
      fbyte = efta_pkg::TAIL0;
    end else if (idx == IW'(20)) begin
      fbyte = efta_pkg::TAIL1;
    end else if (idx == IW'(21)) begin
      fbyte = efta_pkg::TAIL2;
    end
  end

  // Emitter control and output word valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        active <= 1'b1;
        idx    <= '0;
      end
      if (emit) begin
        out_valid <= 1'b1;
        idx       <= idx + 1'b1;
        if (last) begin
          active <= 1'b0;
        end
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Snapshot and output word payload.
  always_ff @(posedge clk) begin
    if (take) begin
      snap <= head.snap;
    end
    if (emit) begin
      result <= '{tx_byte: fbyte, frame_last: last};
    end
  end

endmodule

`default_nettype wire

### rtl/core/encoder_frame_to_angle_telemetry.sv
`default_nettype none

// Encoder position decoder with telemetry frame output. Each input word is
// either a received serial byte or a send request, and one word is taken
// every cycle unless full is high. Position messages (id 1..ENCODER_COUNT,
// 0x03 0x04 0x00, then a 24-bit count) are found in the byte stream and turned
// into an angle in hundredths of a degree by a four-stage pipeline (scale,
// shift and saturate, two reciprocal-multiply digit steps); a send request
// travels the same pipeline, so a frame reflects every message received
// before it. A frame snapshot then waits in a two-entry queue while the
// emitter drives FRAME_BYTES result words, one per cycle when pop is held,
// and takes the next snapshot only once the last word of a frame is out.
// full rises only when both queue entries are taken and a further send
// request has reached the end of the pipeline. No clearing pass follows
// reset. The shift res is written through cfg_we and cfg_data and applies
// to every message that has not yet passed the shift and saturate stage.
module encoder_frame_to_angle_telemetry #(
  parameter int ENCODER_COUNT = efta_pkg::ENCODER_COUNT_DEF,
  parameter int FRAME_BYTES   = efta_pkg::FRAME_BYTES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [4:0]        cfg_data,
  input  wire logic              push,
  input  wire efta_pkg::item_t   item,
  output logic                   full,
  output logic                   empty,
  input  wire logic              pop,
  output efta_pkg::result_t      result
);

  efta_pkg::link_t      q_in;
  efta_pkg::link_t      q_head;
  logic                 q_full;
  efta_pkg::back_stat_t b_stat;

  // Stream matching and angle math.
  efta_front #(
    .ENCODER_COUNT(ENCODER_COUNT)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .push     (push),
    .item     (item),
    .full     (full),
    .q_full   (q_full),
    .snap_out (q_in)
  );

  // Frame snapshots waiting for the emitter.
  efta_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .in_link (q_in),
    .full    (q_full),
    .head    (q_head),
    .take    (b_stat.take)
  );

  // Frame emitter.
  efta_back #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (q_head),
    .stat   (b_stat),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

`ifndef SYNTHESIS
  // The front stalls only for lack of queue space.
  a_full_needs_queue_full: assert property (@(posedge clk) disable iff (rst)
    full |-> q_full)
    else $error("front stalled while the queue had space");

  // The emitter never takes from an empty queue.
  a_take_nonempty: assert property (@(posedge clk) disable iff (rst)
    b_stat.take |-> q_head.valid)
    else $error("emitter took from an empty queue");

  // A snapshot take always starts a frame; take itself requires an idle emitter.
  a_take_when_idle: assert property (@(posedge clk) disable iff (rst)
    b_stat.take |=> b_stat.active)
    else $error("emitter did not start after taking a snapshot");
`endif

endmodule

`default_nettype wire
